// File: src/i2cts_pkg.sv
// Shared types, codes and constants for the I2C transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cts_pkg;

   // Default depth of the target transmit store.
   localparam int TS_BUF_DEPTH = 64;

   // Store positions travel at this width; it covers every legal depth.
   localparam int STORE_IDX_W = 8;

   // Command and bus event codes.
   localparam logic [3:0] CMD_START      = 4'd0;
   localparam logic [3:0] CMD_PROBE      = 4'd1;
   localparam logic [3:0] CMD_ADDR_MATCH = 4'd2;
   localparam logic [3:0] CMD_NACK       = 4'd3;
   localparam logic [3:0] CMD_TX_REQ     = 4'd4;
   localparam logic [3:0] CMD_RX_BYTE    = 4'd5;
   localparam logic [3:0] CMD_TC         = 4'd6;
   localparam logic [3:0] CMD_STOP       = 4'd7;
   localparam logic [3:0] CMD_ABORT      = 4'd8;
   localparam logic [3:0] CMD_LOAD       = 4'd9;

   // Actions for the bus engine.
   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_SEND        = 3'd1;
   localparam logic [2:0] ACT_STORE       = 3'd2;
   localparam logic [2:0] ACT_START_WRITE = 3'd3;
   localparam logic [2:0] ACT_START_READ  = 3'd4;
   localparam logic [2:0] ACT_STOP        = 3'd5;

   // Reply codes.
   localparam logic [1:0] REPLY_OK      = 2'd0;
   localparam logic [1:0] REPLY_BUSY    = 2'd1;
   localparam logic [1:0] REPLY_IGNORED = 2'd2;

   // Roles.
   localparam logic [1:0] ROLE_IDLE   = 2'd0;
   localparam logic [1:0] ROLE_MASTER = 2'd1;
   localparam logic [1:0] ROLE_TARGET = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TX_LENGTH = 1'b0;
   localparam logic CSR_RX_LENGTH = 1'b1;

   // Byte sent by a target that has run out of data.
   localparam logic [7:0] FILL_BYTE = 8'hFF;

   typedef struct packed {
      logic [3:0] cmd;
      logic [6:0] target_addr;
      logic [7:0] tx_count;
      logic [7:0] rx_count;
      logic [7:0] data_in;
      logic [5:0] load_index;
      logic       bus_busy;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_out;
      logic [7:0] store_offset;
      logic [7:0] start_addr;
      logic [7:0] start_length;
      logic       soft_end;
      logic [1:0] reply;
      logic       transfer_done;
      logic       error_seen;
      logic [1:0] role_now;
      logic       busy_now;
   } rsp_type;

   // Write request into the target transmit store.
   typedef struct packed {
      logic                   en;
      logic [STORE_IDX_W-1:0] addr;
      logic [7:0]             data;
   } store_wr_type;

endpackage

`default_nettype wire

// File: src/i2cts_store.sv
// Target transmit store: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps
`default_nettype none

module i2cts_store #(
   parameter int DEPTH = i2cts_pkg::TS_BUF_DEPTH
) (
   input  wire logic                                 clock,
   input  wire i2cts_pkg::store_wr_type              wr,
   input  wire logic [i2cts_pkg::STORE_IDX_W-1:0]    rd_addr,
   output logic      [7:0]                           rd_data
);
   import i2cts_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // A write to the address being read this cycle forwards its data.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/i2cts_engine.sv
// Sequencer state and the single-pass decode of one command or bus event.
`timescale 1ns / 1ps
`default_nettype none

module i2cts_engine #(
   parameter int DEPTH = i2cts_pkg::TS_BUF_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire i2cts_pkg::req_type                item,
   input  wire logic [6:0]                        tx_length,
   input  wire logic [6:0]                        rx_length,
   input  wire logic [7:0]                        rd_data,
   output i2cts_pkg::rsp_type                     rsp_in,
   output i2cts_pkg::store_wr_type                wr,
   output logic      [i2cts_pkg::STORE_IDX_W-1:0] rd_addr
);
   import i2cts_pkg::*;

   localparam logic [8:0] DEPTH_W = 9'(DEPTH);

   logic [1:0] role_ff,    role_in;
   logic       busy_ff,    busy_in;
   logic       done_ff,    done_in;
   logic       err_ff,     err_in;
   logic [7:0] addr_ff,    addr_in;
   logic [7:0] tx_left_ff, tx_left_in;
   logic [7:0] rx_left_ff, rx_left_in;
   logic [7:0] rx_pos_ff,  rx_pos_in;
   logic [6:0] ttx_pos_ff, ttx_pos_in;
   logic [6:0] trx_pos_ff, trx_pos_in;
   logic       tx_irq_ff,  tx_irq_in;
   logic       tc_irq_ff,  tc_irq_in;

   logic       start_refused;
   logic       tc_both;
   logic       ttx_has_byte;
   logic       load_in_range;
   logic [7:0] new_addr;

   assign start_refused = busy_ff || (role_ff == ROLE_TARGET) || item.bus_busy;
   assign tc_both       = (item.tx_count != 8'd0) && (item.rx_count != 8'd0);
   assign new_addr      = {item.target_addr, 1'b0};
   assign ttx_has_byte  = (ttx_pos_ff < tx_length) && ({2'b00, ttx_pos_ff} < DEPTH_W);
   assign load_in_range = {3'b000, item.load_index} < DEPTH_W;

   always_comb begin
      role_in    = role_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;
      err_in     = err_ff;
      addr_in    = addr_ff;
      tx_left_in = tx_left_ff;
      rx_left_in = rx_left_ff;
      rx_pos_in  = rx_pos_ff;
      ttx_pos_in = ttx_pos_ff;
      trx_pos_in = trx_pos_ff;
      tx_irq_in  = tx_irq_ff;
      tc_irq_in  = tc_irq_ff;

      rsp_in              = '0;
      rsp_in.action       = ACT_NONE;
      rsp_in.reply        = REPLY_OK;

      wr.en   = 1'b0;
      wr.addr = {2'b00, item.load_index};
      wr.data = item.data_in;

      unique case (item.cmd) inside
         CMD_START, CMD_PROBE: begin
            if (start_refused) begin
               rsp_in.reply = REPLY_BUSY;
            end else begin
               role_in   = ROLE_MASTER;
               busy_in   = 1'b1;
               done_in   = 1'b0;
               err_in    = 1'b0;
               addr_in   = new_addr;
               rx_pos_in = 8'd0;
               if (item.cmd == CMD_PROBE) begin
                  tx_left_in         = 8'd0;
                  rx_left_in         = 8'd0;
                  rsp_in.action      = ACT_START_WRITE;
                  rsp_in.start_addr  = new_addr;
               end else begin
                  tx_left_in = item.tx_count;
                  rx_left_in = item.rx_count;
                  tc_irq_in  = tc_both;
                  if (item.tx_count != 8'd0) begin
                     rsp_in.action       = ACT_START_WRITE;
                     rsp_in.start_addr   = new_addr;
                     rsp_in.start_length = item.tx_count;
                     rsp_in.soft_end     = tc_both;
                     tx_irq_in           = 1'b1;
                  end else if (item.rx_count != 8'd0) begin
                     rsp_in.action       = ACT_START_READ;
                     rsp_in.start_addr   = new_addr;
                     rsp_in.start_length = item.rx_count;
                  end
               end
            end
         end
         CMD_ADDR_MATCH: begin
            role_in    = ROLE_TARGET;
            ttx_pos_in = 7'd0;
            trx_pos_in = 7'd0;
            tx_irq_in  = 1'b1;
         end
         CMD_NACK: begin
            if (role_ff == ROLE_MASTER) begin
               rsp_in.action = ACT_STOP;
               err_in        = 1'b1;
            end else begin
               rsp_in.reply = REPLY_IGNORED;
            end
         end
         CMD_TX_REQ: begin
            if (!tx_irq_ff) begin
               rsp_in.reply = REPLY_IGNORED;
            end else if (role_ff == ROLE_MASTER) begin
               if (tx_left_ff != 8'd0) begin
                  rsp_in.action   = ACT_SEND;
                  rsp_in.byte_out = item.data_in;
                  tx_left_in      = tx_left_ff - 8'd1;
               end
            end else if (role_ff == ROLE_TARGET) begin
               rsp_in.action = ACT_SEND;
               if (ttx_has_byte) begin
                  rsp_in.byte_out = rd_data;
                  ttx_pos_in      = ttx_pos_ff + 7'd1;
               end else begin
                  rsp_in.byte_out = FILL_BYTE;
               end
            end else begin
               busy_in   = 1'b0;
               tx_irq_in = 1'b0;
            end
         end
         CMD_RX_BYTE: begin
            if (role_ff == ROLE_MASTER) begin
               if (rx_left_ff != 8'd0) begin
                  rsp_in.action       = ACT_STORE;
                  rsp_in.byte_out     = item.data_in;
                  rsp_in.store_offset = rx_pos_ff;
                  rx_pos_in           = rx_pos_ff + 8'd1;
                  rx_left_in          = rx_left_ff - 8'd1;
               end
            end else if (role_ff == ROLE_TARGET) begin
               if (trx_pos_ff < rx_length) begin
                  rsp_in.action       = ACT_STORE;
                  rsp_in.byte_out     = item.data_in;
                  rsp_in.store_offset = {1'b0, trx_pos_ff};
                  trx_pos_in          = trx_pos_ff + 7'd1;
               end
            end else begin
               rsp_in.reply = REPLY_IGNORED;
            end
         end
         CMD_TC: begin
            if (!tc_irq_ff || (role_ff != ROLE_MASTER)) begin
               rsp_in.reply = REPLY_IGNORED;
            end else if (rx_left_ff != 8'd0) begin
               rsp_in.action       = ACT_START_READ;
               rsp_in.start_addr   = addr_ff;
               rsp_in.start_length = rx_left_ff;
               tx_irq_in           = 1'b0;
            end else begin
               tc_irq_in = 1'b0;
            end
         end
         CMD_STOP: begin
            if (role_ff == ROLE_MASTER) begin
               tx_irq_in = 1'b0;
               done_in   = 1'b1;
               busy_in   = 1'b0;
               role_in   = ROLE_IDLE;
            end else if (role_ff == ROLE_TARGET) begin
               tx_irq_in = 1'b0;
               role_in   = ROLE_IDLE;
            end else begin
               rsp_in.reply = REPLY_IGNORED;
            end
         end
         CMD_ABORT: begin
            tx_irq_in = 1'b0;
            if (item.bus_busy) begin
               rsp_in.action = ACT_STOP;
            end
            addr_in    = 8'd0;
            tx_left_in = 8'd0;
            rx_left_in = 8'd0;
            rx_pos_in  = 8'd0;
            done_in    = 1'b1;
            busy_in    = 1'b0;
            role_in    = ROLE_IDLE;
         end
         CMD_LOAD: begin
            wr.en = load_in_range;
         end
         default: begin
            rsp_in.reply = REPLY_IGNORED;
         end
      endcase

      // Flags reported are those after this step.
      rsp_in.transfer_done = done_in;
      rsp_in.error_seen    = err_in;
      rsp_in.role_now      = role_in;
      rsp_in.busy_now      = busy_in;

      // Without a firing item the state holds and so must the write port.
      if (!fire) begin
         wr.en = 1'b0;
      end
   end

   // Prefetch the store at the transmit position the next item will see.
   assign rd_addr = fire ? {1'b0, ttx_pos_in} : {1'b0, ttx_pos_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff    <= ROLE_IDLE;
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         err_ff     <= 1'b0;
         addr_ff    <= 8'd0;
         tx_left_ff <= 8'd0;
         rx_left_ff <= 8'd0;
         rx_pos_ff  <= 8'd0;
         ttx_pos_ff <= 7'd0;
         trx_pos_ff <= 7'd0;
         tx_irq_ff  <= 1'b0;
         tc_irq_ff  <= 1'b0;
      end else if (fire) begin
         role_ff    <= role_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         err_ff     <= err_in;
         addr_ff    <= addr_in;
         tx_left_ff <= tx_left_in;
         rx_left_ff <= rx_left_in;
         rx_pos_ff  <= rx_pos_in;
         ttx_pos_ff <= ttx_pos_in;
         trx_pos_ff <= trx_pos_in;
         tx_irq_ff  <= tx_irq_in;
         tc_irq_ff  <= tc_irq_in;
      end
   end

endmodule

`default_nettype wire

// File: src/i2c_transfer_sequencer.sv
// Top level of the I2C transfer sequencer: request and response registers, CSRs, engine.
`timescale 1ns / 1ps
`default_nettype none

// The sequencer takes one request per clock while the response is not stalled, each a
// command (start, probe, abort, load of a target transmit byte) or a bus event (address
// match, NACK, transmit request, received byte, transfer complete, stop), and answers
// every request with exactly one response telling the bus engine what to do next, along
// with the role, busy, done and error flags as they stand after that request. A request
// is captured in an input register, decoded in one pass against the sequencer state,
// and the response is held in an output register; while a response stalls, a new
// request can still enter an empty input register. The target transmit store is a RAM
// with a registered read port; it is read ahead at the transmit position the next
// request will see, with writes to that same position forwarded, so serving a target
// byte need not wait on the read. Store entries that were never loaded read back as
// unspecified data. Program the two length registers only while no request is in flight.
module i2c_transfer_sequencer #(
   parameter int TARGET_BUF_DEPTH = i2cts_pkg::TS_BUF_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire i2cts_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output i2cts_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [6:0]         csr_data
);
   import i2cts_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_item_ff;
   logic [6:0]             tx_length_ff;
   logic [6:0]             rx_length_ff;

   logic                   exec_fire;
   logic                   req_accept;
   rsp_type                rsp_in;
   store_wr_type           store_wr;
   logic [STORE_IDX_W-1:0] store_rd_addr;
   logic [7:0]             store_rd_data;

   // The held request executes whenever the response register is free or draining.
   assign exec_fire  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !exec_fire;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (exec_fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = exec_fire ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_data;
      end
      if (exec_fire) begin
         out_item_ff <= rsp_in;
      end
   end

   // Configuration registers are always ready to take a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_length_ff <= 7'd0;
         rx_length_ff <= 7'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TX_LENGTH: tx_length_ff <= csr_data;
            CSR_RX_LENGTH: rx_length_ff <= csr_data;
            default:       tx_length_ff <= tx_length_ff;
         endcase
      end
   end

   i2cts_engine #(
      .DEPTH (TARGET_BUF_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (exec_fire),
      .item      (in_item_ff),
      .tx_length (tx_length_ff),
      .rx_length (rx_length_ff),
      .rd_data   (store_rd_data),
      .rsp_in    (rsp_in),
      .wr        (store_wr),
      .rd_addr   (store_rd_addr)
   );

   i2cts_store #(
      .DEPTH (TARGET_BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

`ifndef NO_ASSERTIONS
   // Every executed request produces a response in the following cycle.
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid)
      else $error("executed request did not produce a response");

   // A refused start never launches any bus action.
   a_refused_no_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.reply == REPLY_BUSY)) |-> (rsp_data.action == ACT_NONE))
      else $error("refused start carries an action");

   // Soft end only accompanies the write phase of a write-then-read transfer.
   a_soft_end_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.soft_end) |->
         ((rsp_data.action == ACT_START_WRITE) && (rsp_data.start_length != 8'd0)))
      else $error("soft end without a write start");
`endif

endmodule

`default_nettype wire
